FILE: hdl/pip_pkg.sv
package pip_pkg;

    // Coordinate width, fixed by the item fields
    localparam int COORD_BITS = 16;
    // Default polygon capacity
    localparam int MAX_VERTICES_DEF = 256;

    // Item opcodes
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]                   mode;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
    } in_item_t;

    typedef struct packed {
        logic inside_res;
        logic vertices_dropped;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load_pt;   // latch query point, clear parity
        logic mem_wr;    // store vertex at write address
        logic rd_en;     // read vertex at read address
        logic rd_first;  // this read only primes the previous vertex
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic busy;      // edge pipeline still holds work
        logic parity;    // running crossing parity
    } sts_t;

endpackage

FILE: hdl/pip_datapath.sv
module pip_datapath #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pip_pkg::cmd_t                   cmd,
    input  pip_pkg::in_item_t               in_data,
    input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    output pip_pkg::sts_t                   sts
);
    import pip_pkg::*;

    localparam int W = COORD_BITS;
    localparam int D = COORD_BITS + 1;

    // Vertex memory: {x, y} per entry
    logic [2*W-1:0] vmem [MAX_VERTICES];

    logic signed [W-1:0] px_reg, py_reg;
    logic signed [W-1:0] rdx_reg, rdy_reg;
    logic signed [W-1:0] prevx_reg, prevy_reg;
    logic                rdd_v_reg, rd_v_reg;

    // Stage 1: bounds tests and differences
    logic signed [W-1:0] ymin, ymax, xmax;
    logic signed [D-1:0] dy_raw, ex_raw;
    logic                s1_v_reg, s1_hit_reg, s1_vert_reg;
    logic                s1_hit_next, s1_vert_next;
    logic signed [D-1:0] s1_a_reg, s1_dy_reg, s1_b_reg, s1_ex_reg;
    logic signed [D-1:0] s1_a_next, s1_dy_next, s1_b_next, s1_ex_next;

    // Stage 2: cross products
    logic                  s2_v_reg, s2_hit_reg, s2_vert_reg;
    logic signed [2*D-1:0] s2_pa_reg, s2_pb_reg;
    logic signed [2*D-1:0] s2_pa_next, s2_pb_next;

    // Stage 3: parity
    logic parity_reg, parity_next;
    logic toggle;

    always_comb
    begin
        ymin = (prevy_reg < rdy_reg) ? prevy_reg : rdy_reg;
        ymax = (prevy_reg < rdy_reg) ? rdy_reg : prevy_reg;
        xmax = (prevx_reg < rdx_reg) ? rdx_reg : prevx_reg;
        s1_hit_next  = (py_reg > ymin) && (py_reg <= ymax) && (px_reg <= xmax);
        s1_vert_next = (prevx_reg == rdx_reg);
        dy_raw = D'(rdy_reg) - D'(prevy_reg);
        ex_raw = D'(rdx_reg) - D'(prevx_reg);
        // Make dy positive so the inequality keeps its direction
        if (dy_raw < 0)
        begin
            s1_dy_next = -dy_raw;
            s1_ex_next = -ex_raw;
        end
        else
        begin
            s1_dy_next = dy_raw;
            s1_ex_next = ex_raw;
        end
        s1_a_next = D'(px_reg) - D'(prevx_reg);
        s1_b_next = D'(py_reg) - D'(prevy_reg);
    end

    assign s2_pa_next = s1_a_reg * s1_dy_reg;
    assign s2_pb_next = s1_b_reg * s1_ex_reg;

    assign toggle = s2_v_reg && s2_hit_reg && (s2_vert_reg || (s2_pa_reg <= s2_pb_reg));

    always_comb
    begin
        parity_next = parity_reg;
        if (cmd.load_pt)
            parity_next = 1'b0;
        else if (toggle)
            parity_next = ~parity_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            vmem[wr_addr] <= {in_data.coord_x, in_data.coord_y};
        if (cmd.rd_en)
            {rdx_reg, rdy_reg} <= vmem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pt)
        begin
            px_reg <= in_data.coord_x;
            py_reg <= in_data.coord_y;
        end
        if (rdd_v_reg)
        begin
            prevx_reg <= rdx_reg;
            prevy_reg <= rdy_reg;
        end
        s1_hit_reg  <= s1_hit_next;
        s1_vert_reg <= s1_vert_next;
        s1_a_reg    <= s1_a_next;
        s1_dy_reg   <= s1_dy_next;
        s1_b_reg    <= s1_b_next;
        s1_ex_reg   <= s1_ex_next;
        s2_hit_reg  <= s1_hit_reg;
        s2_vert_reg <= s1_vert_reg;
        s2_pa_reg   <= s2_pa_next;
        s2_pb_reg   <= s2_pb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdd_v_reg  <= 1'b0;
            rd_v_reg   <= 1'b0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            parity_reg <= 1'b0;
        end
        else
        begin
            rdd_v_reg  <= cmd.rd_en;
            rd_v_reg   <= cmd.rd_en && !cmd.rd_first;
            s1_v_reg   <= rd_v_reg;
            s2_v_reg   <= s1_v_reg;
            parity_reg <= parity_next;
        end
    end

    assign sts.busy   = rdd_v_reg || s1_v_reg || s2_v_reg;
    assign sts.parity = parity_reg;

endmodule

FILE: hdl/pip_ctrl.sv
module pip_ctrl #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  pip_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output pip_pkg::out_item_t              out_data,
    output pip_pkg::cmd_t                   cmd,
    output logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    output logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    input  pip_pkg::sts_t                   sts
);
    import pip_pkg::*;

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] last_idx;
    logic              first_reg, first_next;
    logic              dropped_reg, dropped_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;
    logic              accept;
    logic              out_load;

    assign last_idx = ADDR_W'(count_reg - 1'b1);
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign rd_addr  = idx_reg;
    assign wr_addr  = count_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        first_next   = first_reg;
        dropped_next = dropped_reg;
        cmd          = '0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.mode)
                        MODE_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_VERTICES))
                            begin
                                cmd.mem_wr = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                                dropped_next = 1'b1;
                        end
                        MODE_CLEAR:
                            count_next = '0;
                        MODE_QUERY:
                        begin
                            cmd.load_pt = 1'b1;
                            if (count_reg == '0)
                                state_next = ST_FINISH;
                            else
                            begin
                                state_next = ST_WALK;
                                idx_next   = last_idx;
                                first_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK:
            begin
                // last vertex first, then 0 .. n-1
                cmd.rd_en    = 1'b1;
                cmd.rd_first = first_reg;
                if (first_reg)
                begin
                    first_next = 1'b0;
                    idx_next   = '0;
                end
                else if (idx_reg == last_idx)
                    state_next = ST_DRAIN;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (!sts.busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (out_load)
        begin
            out_valid_next                 = 1'b1;
            out_data_next.inside_res       = sts.parity;
            out_data_next.vertices_dropped = dropped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            first_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            first_reg     <= first_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hdl/point_in_polygon_test_unit.sv
// Crossing-number point-in-polygon unit.
// Input channel (in_valid / in_stall / in_data) carries one item per transfer:
//   append a vertex, clear the polygon, or query a point. Mode 3 is dropped.
// Output channel (out_valid / out_stall / out_data) carries one result per query:
//   inside parity and the sticky vertices_dropped flag. Appends and clears
//   return nothing.
// Query: the walk reads one vertex per cycle from the vertex memory, then a
//   three-stage edge pipeline (bounds, cross products, compare) drains. An
//   empty polygon skips the walk and goes straight to its result. in_stall
//   stays high while a query runs.
// The result sits in an output register; new appends and clears are taken
//   while it waits. A query that finishes while out_stall holds the previous
//   result waits until that result leaves.
// Reset (rst_n, async, active low) empties the polygon and clears the dropped
//   flag and the output valid flag. The vertex memory itself is not cleared.
module point_in_polygon_test_unit #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pip_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output pip_pkg::out_item_t out_data
);
    import pip_pkg::*;

    localparam int ADDR_W = $clog2(MAX_VERTICES);

    cmd_t              cmd;
    sts_t              sts;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    // Sequencing, vertex count, output register
    pip_ctrl #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .sts      (sts)
    );

    // Vertex memory and edge-test pipeline
    pip_datapath #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .in_data(in_data),
        .rd_addr(rd_addr),
        .wr_addr(wr_addr),
        .sts    (sts)
    );

endmodule

FILE: hdl/pip_checker.sv
module pip_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input pip_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_stall,
    input pip_pkg::out_item_t out_data
);
    import pip_pkg::*;

    // Held result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result dropped or changed under stall");

    // A query occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.mode == MODE_QUERY |=> in_stall)
        else $error("input not stalled after query transfer");

    // A result only appears at the end of a query
    a_res_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a running query");

    // Append, clear and unused modes return nothing
    a_no_res_other: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.mode != MODE_QUERY && !out_valid
        |=> !out_valid)
        else $error("result after a non-query transfer");

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pip_pkg::*;

    // Polygon capacity of the unit under test
    localparam int CAPACITY = MAX_VERTICES_DEF;
    // Mode value with no meaning; the unit drops such a transfer
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Long receiver hold-off, in cycles, to back the unit up
    localparam int LONG_HOLD = 200;
    // Cycles with no transfer on either channel before the run is abandoned
    localparam int QUIET_LIMIT = 2000;
    // Settling time after the last result
    localparam int TAIL_CYCLES = 16;
    // Random stimulus size, split around the overflow phase
    localparam int RANDOM_ITEMS = 470;
    localparam int OVERFLOW_AT = 150;

    // Coordinate extremes
    localparam logic [15:0] C_MIN = 16'h8000;
    localparam logic [15:0] C_MAX = 16'h7FFF;

    // Span code for random coordinates that covers the whole 16-bit range
    localparam int SPAN_FULL = 0;

    // A directed row either carries a result typed in by hand or
    // relies on the predictor alone
    localparam logic TYPED = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam out_item_t RES_OUTSIDE = 2'b00;
    localparam out_item_t RES_INSIDE = 2'b10;
    localparam out_item_t RES_NONE = 2'b00;

    typedef struct packed {
        in_item_t  item;
        logic      known;
        out_item_t want;
    } directed_row_t;

    // Expected query answer: predictor value plus an optional hand value
    typedef struct packed {
        out_item_t pred;
        logic      known;
        out_item_t typed;
    } query_answer_t;

    // Per-transfer hand check, queued in send order
    typedef struct packed {
        logic      known;
        out_item_t want;
    } hand_check_t;

    // Directed stimulus: empty / one / two vertex polygons, ignored mode,
    // full-range square with points on corners and edges, then a triangle
    // with points on and just off its slanted edge, one inside and one to its left.
    localparam int N_DIRECTED = 25;
    localparam directed_row_t DIRECTED [N_DIRECTED] = '{
        {MODE_QUERY,  16'h0000, 16'h0000, TYPED,     RES_OUTSIDE},
        {MODE_APPEND, 16'h0000, 16'h0000, PREDICTED, RES_NONE},
        {MODE_QUERY,  16'h0000, 16'h0000, TYPED,     RES_OUTSIDE},
        {MODE_APPEND, 16'd10,   16'd5,    PREDICTED, RES_NONE},
        {MODE_QUERY,  16'd5,    16'd3,    TYPED,     RES_OUTSIDE},
        {MODE_UNUSED, C_MAX,    C_MIN,    PREDICTED, RES_NONE},
        {MODE_CLEAR,  C_MIN,    C_MAX,    PREDICTED, RES_NONE},
        {MODE_APPEND, C_MIN,    C_MIN,    PREDICTED, RES_NONE},
        {MODE_APPEND, C_MAX,    C_MIN,    PREDICTED, RES_NONE},
        {MODE_APPEND, C_MAX,    C_MAX,    PREDICTED, RES_NONE},
        {MODE_APPEND, C_MIN,    C_MAX,    PREDICTED, RES_NONE},
        {MODE_QUERY,  16'h0000, 16'h0000, TYPED,     RES_INSIDE},
        {MODE_QUERY,  C_MIN,    C_MIN,    PREDICTED, RES_NONE},
        {MODE_QUERY,  C_MAX,    C_MAX,    PREDICTED, RES_NONE},
        {MODE_QUERY,  C_MIN,    C_MAX,    PREDICTED, RES_NONE},
        {MODE_QUERY,  16'h0000, C_MIN,    PREDICTED, RES_NONE},
        {MODE_QUERY,  C_MAX,    16'h0000, PREDICTED, RES_NONE},
        {MODE_CLEAR,  16'h0000, 16'h0000, PREDICTED, RES_NONE},
        {MODE_APPEND, 16'h0000, 16'h0000, PREDICTED, RES_NONE},
        {MODE_APPEND, 16'd100,  16'h0000, PREDICTED, RES_NONE},
        {MODE_APPEND, 16'h0000, 16'd100,  PREDICTED, RES_NONE},
        {MODE_QUERY,  16'd50,   16'd50,   PREDICTED, RES_NONE},
        {MODE_QUERY,  16'd51,   16'd50,   PREDICTED, RES_NONE},
        {MODE_QUERY,  16'd20,   16'd20,   TYPED,     RES_INSIDE},
        {MODE_QUERY,  16'hFFFF, 16'd50,   PREDICTED, RES_NONE}
    };

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    // No idling on either side while set; redrawn per random sequence
    bit burst = 1'b0;
    // Raised by the stimulus to ask the receiver for one long hold-off
    bit long_hold_req = 1'b0;

    int fail_count = 0;
    int item_count = 0;
    int quiet_cycles = 0;

    // Predictor state: the polygon as the unit should hold it
    logic signed [15:0] poly_x [CAPACITY];
    logic signed [15:0] poly_y [CAPACITY];
    int unsigned        poly_count = 0;
    logic               poly_dropped = 1'b0;

    query_answer_t pending_results [$];
    hand_check_t   sent_checks [$];

    point_in_polygon_test_unit #(
        .MAX_VERTICES(CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Does the rightward ray from (px, py) cross edge (x1,y1)-(x2,y2)?
    // Half-open in y so a shared vertex counts once; horizontal edges
    // never pass the y test. The crossing x is compared exactly by
    // cross-multiplying with dy made positive; 64-bit is ample for
    // 17-bit differences.
    function automatic bit edge_crosses(longint px, longint py,
                                        longint x1, longint y1,
                                        longint x2, longint y2);
        longint ymin;
        longint ymax;
        longint xmax;
        longint dy;
        longint ex;
        ymin = (y1 < y2) ? y1 : y2;
        ymax = (y1 < y2) ? y2 : y1;
        xmax = (x1 < x2) ? x2 : x1;
        if (!(py > ymin && py <= ymax && px <= xmax))
            return 1'b0;
        if (x1 == x2)
            return 1'b1;
        dy = y2 - y1;
        ex = x2 - x1;
        if (dy < 0)
        begin
            dy = -dy;
            ex = -ex;
        end
        return (px - x1) * dy <= (py - y1) * ex;
    endfunction

    // Crossing parity over every edge, closing edge included
    function automatic logic point_inside(longint px, longint py);
        logic        parity;
        int unsigned prev;
        parity = 1'b0;
        for (int unsigned i = 0; i < poly_count; i++)
        begin
            prev = (i == 0) ? poly_count - 1 : i - 1;
            if (edge_crosses(px, py, poly_x[prev], poly_y[prev], poly_x[i], poly_y[i]))
                parity = ~parity;
        end
        return parity;
    endfunction

    // Apply one accepted transfer; a query queues its expected answer
    task automatic track_item(input in_item_t it, input hand_check_t chk);
        query_answer_t ans;
        case (it.mode)
            MODE_APPEND:
            begin
                if (poly_count < CAPACITY)
                begin
                    poly_x[poly_count] = $signed(it.coord_x);
                    poly_y[poly_count] = $signed(it.coord_y);
                    poly_count++;
                end
                else
                    poly_dropped = 1'b1;
            end
            MODE_CLEAR:
                poly_count = 0;
            MODE_QUERY:
            begin
                ans.pred.inside_res       = point_inside($signed(it.coord_x),
                                                         $signed(it.coord_y));
                ans.pred.vertices_dropped = poly_dropped;
                ans.known                 = chk.known;
                ans.typed                 = chk.want;
                pending_results = {pending_results, ans};
            end
            default: ;
        endcase
    endtask

    task automatic compare_fields(input out_item_t got, input out_item_t want);
        if (got.inside_res !== want.inside_res)
        begin
            $error("inside_res: expected %0b, got %0b", want.inside_res, got.inside_res);
            fail_count++;
        end
        if (got.vertices_dropped !== want.vertices_dropped)
        begin
            $error("vertices_dropped: expected %0b, got %0b",
                   want.vertices_dropped, got.vertices_dropped);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: both channels sampled at the edge, before any update lands
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        query_answer_t ans;
        hand_check_t   chk;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                chk = '0;
                if (sent_checks.size() != 0)
                    chk = sent_checks.pop_front();
                track_item(in_data, chk);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with nothing expected: inside_res %0b",
                           out_data.inside_res);
                    fail_count++;
                end
                else
                begin
                    ans = pending_results.pop_front();
                    compare_fields(out_data, ans.pred);
                    if (ans.known)
                        compare_fields(out_data, ans.typed);
                end
            end
        end
    end

    // Watchdog: a run that stops moving is a failure
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random hold-off before each result, one long hold-off
    // on request. Stall may rise before a result shows up, so gaps land
    // on every phase of a query.
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            else
                hold = burst ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid && !long_hold_req)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // One transfer with a random lead-in gap. Valid stays high across
    // back-to-back transfers; it only drops when a gap is drawn.
    task automatic send_item(input in_item_t it, input logic known, input out_item_t want);
        int          gap;
        hand_check_t chk;
        gap = burst ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chk.known = known;
        chk.want  = want;
        sent_checks = {sent_checks, chk};
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (it.mode != MODE_UNUSED)
            item_count++;
    endtask

    function automatic in_item_t make_item(logic [1:0] mode, logic [15:0] x, logic [15:0] y);
        in_item_t it;
        it.mode    = mode;
        it.coord_x = x;
        it.coord_y = y;
        return it;
    endfunction

    // Small spans crowd vertices together: shared x or y, horizontal and
    // vertical edges, points on edges and corners
    function automatic logic [15:0] pick_coord(int span);
        int v;
        if (span == SPAN_FULL)
            return 16'($urandom());
        v = $urandom_range(0, 2 * span);
        v = v - span;
        return v[15:0];
    endfunction

    task automatic send_random(logic [1:0] mode, int span);
        send_item(make_item(mode, pick_coord(span), pick_coord(span)), PREDICTED, RES_NONE);
    endtask

    // Sender holds off until every expected result has arrived
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly a fresh polygon followed by queries over the same area;
    // the rest is noise: any mode, full-range coordinates, appends onto
    // whatever polygon is left.
    task automatic run_random_sequence();
        int kind;
        int span;
        int nv;
        int nq;
        burst = ($urandom_range(0, 4) == 0);
        kind  = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
            0:       span = 8;
            1:       span = 40;
            2:       span = 2000;
            default: span = SPAN_FULL;
        endcase
        if (kind < 8)
        begin
            if ($urandom_range(0, 5) != 0)
                send_random(MODE_CLEAR, SPAN_FULL);
            nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            repeat (nv)
            begin
                send_random(MODE_APPEND, span);
                if ($urandom_range(0, 15) == 0)
                    send_random(MODE_UNUSED, SPAN_FULL);
            end
            nq = $urandom_range(1, 6);
            repeat (nq)
                send_random(MODE_QUERY, ($urandom_range(0, 7) == 0) ? SPAN_FULL : span);
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                send_random(2'($urandom_range(0, 3)), SPAN_FULL);
        end
        if ($urandom_range(0, 9) == 0)
            wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; rows with a typed-in answer are checked twice
        foreach (DIRECTED[i])
            send_item(DIRECTED[i].item, DIRECTED[i].known, DIRECTED[i].want);

        // Back-pressure: receiver holds off while queries and appends keep
        // coming, so the output register fills and the unit stalls its input
        wait_results_drained();
        send_random(MODE_CLEAR, SPAN_FULL);
        repeat (4)
            send_random(MODE_APPEND, 40);
        long_hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_random((i % 3 == 0) ? MODE_APPEND : MODE_QUERY, 40);
        wait_results_drained();

        item_count = 0;
        while (item_count < OVERFLOW_AT)
            run_random_sequence();

        // Fill the store to capacity, push past it, then query the full
        // polygon; the dropped flag stays set for the rest of the run
        wait_results_drained();
        burst = 1'b0;
        send_random(MODE_CLEAR, SPAN_FULL);
        repeat (CAPACITY + 4)
            send_random(MODE_APPEND, 40);
        repeat (3)
            send_random(MODE_QUERY, 40);

        while (item_count < RANDOM_ITEMS)
            run_random_sequence();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/pip_pkg.sv
hdl/pip_datapath.sv
hdl/pip_ctrl.sv
hdl/point_in_polygon_test_unit.sv
hdl/pip_checker.sv
tb/tb_top.sv
